// ----- rtl/vnm_pkg.sv -----
package vnm_pkg;

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] target_magnitude;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               zero_vector;
        logic               saturated;
    } t_out;

    // Square-root stages (one root bit per stage, from two bits of the 64-bit sum).
    localparam int ROOT_STEPS = 32;
    // Quotient bits, one per divider stage.
    localparam int QUO_BITS   = 32;
    // The length never exceeds sqrt(3) * 2^31, so 33 bits hold it.
    localparam int LEN_W      = 33;
    // Magnitude product of a component and a target of up to 33 bits.
    localparam int DIVD_W     = 65;

    // Magnitude of a signed 32-bit value; -2^31 maps to 2^31.
    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

endpackage

// ----- rtl/vnm_sqrt.sv -----
module vnm_sqrt
    import vnm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_in                   i_item,
    output logic                  o_valid,
    output logic [LEN_W-1:0]      o_len,
    output t_in                   o_item
);

    // Stage one: three squares. Stage two: their sum.
    logic              r_sq_vld;
    logic [2:0][63:0]  r_sq;
    t_in               r_sq_item;
    logic              r_sum_vld;
    logic [63:0]       r_sum;
    t_in               r_sum_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld  <= 1'b0;
            r_sum_vld <= 1'b0;
        end else if (i_en) begin
            r_sq_vld  <= i_valid;
            r_sum_vld <= r_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq[0]    <= {32'b0, abs32(i_item.vec_x)} * {32'b0, abs32(i_item.vec_x)};
            r_sq[1]    <= {32'b0, abs32(i_item.vec_y)} * {32'b0, abs32(i_item.vec_y)};
            r_sq[2]    <= {32'b0, abs32(i_item.vec_z)} * {32'b0, abs32(i_item.vec_z)};
            r_sq_item  <= i_item;
            r_sum      <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sum_item <= r_sq_item;
        end
    end

    // Digit-by-digit root, one result bit per stage.
    logic        r_rt_vld  [ROOT_STEPS];
    logic [63:0] r_rem     [ROOT_STEPS];
    logic [63:0] r_root    [ROOT_STEPS];
    t_in         r_rt_item [ROOT_STEPS];

    genvar k;
    generate
        for (k = 0; k < ROOT_STEPS; k++) begin : g_root
            localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
            logic        w_vld;
            logic [63:0] w_n;
            logic [63:0] w_r;
            t_in         w_item;
            logic [63:0] w_trial;
            logic [63:0] n_rem;
            logic [63:0] n_root;

            if (k == 0) begin : g_first
                assign w_vld  = r_sum_vld;
                assign w_n    = r_sum;
                assign w_r    = 64'b0;
                assign w_item = r_sum_item;
            end else begin : g_next
                assign w_vld  = r_rt_vld[k-1];
                assign w_n    = r_rem[k-1];
                assign w_r    = r_root[k-1];
                assign w_item = r_rt_item[k-1];
            end

            always_comb begin
                w_trial = w_r + BIT;
                if (w_n >= w_trial) begin
                    n_rem  = w_n - w_trial;
                    n_root = (w_r >> 1) + BIT;
                end else begin
                    n_rem  = w_n;
                    n_root = w_r >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_rt_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_rt_vld[k] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]     <= n_rem;
                    r_root[k]    <= n_root;
                    r_rt_item[k] <= w_item;
                end
            end
        end
    endgenerate

    assign o_valid = r_rt_vld[ROOT_STEPS-1];
    assign o_len   = r_root[ROOT_STEPS-1][LEN_W-1:0];
    assign o_item  = r_rt_item[ROOT_STEPS-1];

endmodule

// ----- rtl/vnm_div.sv -----
module vnm_div
    import vnm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [LEN_W-1:0]           i_len,
    input  t_in                        i_item,
    output logic                       o_valid,
    output logic [2:0][QUO_BITS-1:0]   o_quo,
    output logic [2:0]                 o_neg,
    output logic                       o_zero,
    output t_in                        o_item
);

    // Product stage: |component| * |target| and the sign of each quotient.
    logic                     r_p_vld;
    logic [2:0][DIVD_W-1:0]   r_p_prod;
    logic [2:0]               r_p_neg;
    logic [LEN_W-1:0]         r_p_len;
    t_in                      r_p_item;

    logic [2:0][31:0]         w_comp;
    logic                     w_tzero;
    logic [LEN_W-1:0]         w_tmag;

    always_comb begin
        w_comp[0] = i_item.vec_x;
        w_comp[1] = i_item.vec_y;
        w_comp[2] = i_item.vec_z;
        w_tzero   = (i_item.target_magnitude == 32'sd0);
        // A zero target stands for the current length.
        w_tmag    = w_tzero ? i_len : {1'b0, abs32(i_item.target_magnitude)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_p_prod[l] <= {33'b0, abs32(w_comp[l])} * {32'b0, w_tmag};
                r_p_neg[l]  <= w_tzero ? w_comp[l][31]
                                       : (w_comp[l][31] ^ i_item.target_magnitude[31]);
            end
            r_p_len  <= i_len;
            r_p_item <= i_item;
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes.
    logic                     r_d_vld  [QUO_BITS];
    logic [2:0][DIVD_W-1:0]   r_d_rem  [QUO_BITS];
    logic [2:0][QUO_BITS-1:0] r_d_quo  [QUO_BITS];
    logic [2:0]               r_d_neg  [QUO_BITS];
    logic [LEN_W-1:0]         r_d_len  [QUO_BITS];
    t_in                      r_d_item [QUO_BITS];

    genvar j;
    generate
        for (j = 0; j < QUO_BITS; j++) begin : g_div
            localparam int SH = QUO_BITS - 1 - j;
            logic                     w_vld;
            logic [2:0][DIVD_W-1:0]   w_rem;
            logic [2:0][QUO_BITS-1:0] w_quo;
            logic [2:0]               w_neg;
            logic [LEN_W-1:0]         w_len;
            t_in                      w_item;
            logic [DIVD_W-1:0]        w_dvs;
            logic [2:0][DIVD_W-1:0]   n_rem;
            logic [2:0][QUO_BITS-1:0] n_quo;

            if (j == 0) begin : g_first
                assign w_vld  = r_p_vld;
                assign w_rem  = r_p_prod;
                assign w_quo  = '0;
                assign w_neg  = r_p_neg;
                assign w_len  = r_p_len;
                assign w_item = r_p_item;
            end else begin : g_next
                assign w_vld  = r_d_vld[j-1];
                assign w_rem  = r_d_rem[j-1];
                assign w_quo  = r_d_quo[j-1];
                assign w_neg  = r_d_neg[j-1];
                assign w_len  = r_d_len[j-1];
                assign w_item = r_d_item[j-1];
            end

            always_comb begin
                w_dvs = DIVD_W'(w_len) << SH;
                for (int l = 0; l < 3; l++) begin
                    n_quo[l] = w_quo[l];
                    if (w_rem[l] >= w_dvs) begin
                        n_rem[l]     = w_rem[l] - w_dvs;
                        n_quo[l][SH] = 1'b1;
                    end else begin
                        n_rem[l] = w_rem[l];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_d_vld[j] <= 1'b0;
                end else if (i_en) begin
                    r_d_vld[j] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d_rem[j]  <= n_rem;
                    r_d_quo[j]  <= n_quo;
                    r_d_neg[j]  <= w_neg;
                    r_d_len[j]  <= w_len;
                    r_d_item[j] <= w_item;
                end
            end
        end
    endgenerate

    assign o_valid = r_d_vld[QUO_BITS-1];
    assign o_quo   = r_d_quo[QUO_BITS-1];
    assign o_neg   = r_d_neg[QUO_BITS-1];
    assign o_zero  = (r_d_len[QUO_BITS-1] == '0);
    assign o_item  = r_d_item[QUO_BITS-1];

endmodule

// ----- rtl/vector3_normalize_to_magnitude.sv -----
// Rescales a signed Q16.16 three-component vector to a requested signed
// Q16.16 length while keeping its direction. The length is the floor square
// root of the exact 64-bit sum of squares, and each component becomes
// target * component / length, truncated toward zero and saturated to the
// signed 32-bit range, which raises the saturated flag. A zero target keeps
// the current length, and a negative target reverses the vector. A vector
// of zero length is passed through unchanged with zero_vector set. The
// block is a fully pipelined datapath that accepts one transaction per
// clock cycle while its output side is not stalled. The input register
// captures the transaction at the accepting edge, and after it come the
// square and sum stages, 32 square-root stages, one product stage, 32
// divider stages and the output register. The pipeline advances as a
// whole whenever its output register is empty or being taken, so a stall
// on the output side holds every transaction in place and nothing is lost
// or repeated. The number
// of fraction bits does not enter the arithmetic, since it cancels in the
// quotient.
module vector3_normalize_to_magnitude
    import vnm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_item,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_item
);

    logic r_in_vld;
    t_in  r_in_item;
    logic r_ovld;
    t_out r_out;
    t_out n_out;
    logic w_en;

    logic                     w_sq_vld;
    logic [LEN_W-1:0]         w_len;
    t_in                      w_sq_item;
    logic                     w_dv_vld;
    logic [2:0][QUO_BITS-1:0] w_quo;
    logic [2:0]               w_neg;
    logic                     w_zero;
    t_in                      w_dv_item;

    // The whole pipeline moves when the output register can take a new value.
    assign w_en    = !r_ovld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ovld;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_item <= i_item;
        end
    end

    vnm_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_in_vld),
        .i_item  (r_in_item),
        .o_valid (w_sq_vld),
        .o_len   (w_len),
        .o_item  (w_sq_item)
    );

    vnm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_vld),
        .i_len   (w_len),
        .i_item  (w_sq_item),
        .o_valid (w_dv_vld),
        .o_quo   (w_quo),
        .o_neg   (w_neg),
        .o_zero  (w_zero),
        .o_item  (w_dv_item)
    );

    // Apply the sign, clamp to the 32-bit range, and handle the zero vector.
    always_comb begin
        logic [2:0][31:0] v_res;
        logic             v_sat;
        v_sat = 1'b0;
        for (int l = 0; l < 3; l++) begin
            if (w_neg[l]) begin
                if ({1'b0, w_quo[l]} > 33'h080000000) begin
                    v_sat    = 1'b1;
                    v_res[l] = 32'h80000000;
                end else begin
                    v_res[l] = 32'(-w_quo[l]);
                end
            end else begin
                if (w_quo[l] > 32'h7FFFFFFF) begin
                    v_sat    = 1'b1;
                    v_res[l] = 32'h7FFFFFFF;
                end else begin
                    v_res[l] = w_quo[l];
                end
            end
        end
        if (w_zero) begin
            n_out.out_x       = w_dv_item.vec_x;
            n_out.out_y       = w_dv_item.vec_y;
            n_out.out_z       = w_dv_item.vec_z;
            n_out.zero_vector = 1'b1;
            n_out.saturated   = 1'b0;
        end else begin
            n_out.out_x       = v_res[0];
            n_out.out_y       = v_res[1];
            n_out.out_z       = v_res[2];
            n_out.zero_vector = 1'b0;
            n_out.saturated   = v_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_zero_not_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_out.zero_vector |-> !r_out.saturated)
        else $error("zero vector result flagged as saturated");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> o_ready)
        else $error("pipeline stalled with an empty output register");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_zero_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_out.zero_vector |->
            (r_out.out_x == 32'sd0) && (r_out.out_y == 32'sd0) && (r_out.out_z == 32'sd0))
        else $error("zero vector result has nonzero components");
`endif

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import vnm_pkg::*;

    // A settle period comfortably longer than the pipeline depth lets any
    // straggling transaction show up after the last expectation.
    localparam int PIPE_LATENCY = 68;
    localparam int MAX_REPORTS  = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_item;
    logic o_valid;
    logic i_ready;
    t_out o_item;

    t_out expected_q[$];
    int   mismatch_count;
    int   checked_count;
    int   sat_seen;
    int   zero_seen;
    bit   sink_hold;
    int   ready_gap;

    vector3_normalize_to_magnitude i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Floor square root of a 64-bit value, bit by bit from the top.
    function automatic logic [32:0] floor_root(input logic [63:0] n);
        logic [32:0] r;
        logic [65:0] trial;
        r = '0;
        for (int b = 32; b >= 0; b--) begin
            trial = 66'(r | (33'd1 << b));
            if (trial * trial <= {2'b00, n}) begin
                r = r | (33'd1 << b);
            end
        end
        return r;
    endfunction

    // Computes the rescaled vector expected for one input transaction.
    function automatic t_out rescale_vector(input t_in v);
        t_out r;
        logic [31:0] mag[3];
        logic        neg[3];
        logic [63:0] sum_sq;
        logic [32:0] len;
        logic [32:0] tgt_mag;
        logic        tgt_neg;
        logic [65:0] quo;
        logic [31:0] comp[3];
        mag[0] = v.vec_x[31] ? -v.vec_x : v.vec_x;
        mag[1] = v.vec_y[31] ? -v.vec_y : v.vec_y;
        mag[2] = v.vec_z[31] ? -v.vec_z : v.vec_z;
        neg[0] = v.vec_x[31];
        neg[1] = v.vec_y[31];
        neg[2] = v.vec_z[31];
        sum_sq = 64'(mag[0]) * mag[0] + 64'(mag[1]) * mag[1] + 64'(mag[2]) * mag[2];
        len = floor_root(sum_sq);
        r = '0;
        if (len == 0) begin
            r.out_x = v.vec_x;
            r.out_y = v.vec_y;
            r.out_z = v.vec_z;
            r.zero_vector = 1'b1;
            return r;
        end
        // A zero target stands for the current length, which is positive.
        if (v.target_magnitude == 0) begin
            tgt_mag = len;
            tgt_neg = 1'b0;
        end else begin
            tgt_neg = v.target_magnitude[31];
            tgt_mag = {1'b0, tgt_neg ? -v.target_magnitude : v.target_magnitude};
        end
        for (int i = 0; i < 3; i++) begin
            quo = (66'(mag[i]) * tgt_mag) / len;
            if (neg[i] != tgt_neg) begin
                if (quo > 66'h8000_0000) begin
                    quo = 66'h8000_0000;
                    r.saturated = 1'b1;
                end
                comp[i] = -quo[31:0];
            end else begin
                if (quo > 66'h7FFF_FFFF) begin
                    quo = 66'h7FFF_FFFF;
                    r.saturated = 1'b1;
                end
                comp[i] = quo[31:0];
            end
        end
        r.out_x = comp[0];
        r.out_y = comp[1];
        r.out_z = comp[2];
        return r;
    endfunction

    // Drives one transaction at a falling edge and holds it until accepted.
    // Valid stays high afterwards so that a following transaction with no gap
    // goes out in the very next cycle.
    task automatic send_vector(input t_in v, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_item  = v;
        do @(posedge i_clk); while (!o_ready);
        expected_q.push_back(rescale_vector(v));
    endtask

    // Drops valid after the last transaction of a sequence.
    task automatic stop_input();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [31:0] random_field();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return $urandom_range(0, 255) - 128;
            4: return 32'($signed($urandom_range(0, 32'h3_0000))) - 32'sh1_8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in make_vector(input logic [31:0] x, y, z, t);
        t_in v;
        v.vec_x = x;
        v.vec_y = y;
        v.vec_z = z;
        v.target_magnitude = t;
        return v;
    endfunction

    // Result sink: random back-pressure, checks every completed transaction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("ERROR: unexpected result %h", o_item);
                end
            end else begin
                want = expected_q.pop_front();
                checked_count++;
                if (want.saturated) sat_seen++;
                if (want.zero_vector) zero_seen++;
                if (o_item !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("ERROR: x %h/%h y %h/%h z %h/%h zv %b/%b sat %b/%b",
                            want.out_x, o_item.out_x, want.out_y, o_item.out_y,
                            want.out_z, o_item.out_z, want.zero_vector,
                            o_item.zero_vector, want.saturated, o_item.saturated);
                    end
                end
            end
        end
    end

    // Ready drops for short stretches most of the time and now and then for long ones.
    always @(negedge i_clk) begin
        if (sink_hold) begin
            i_ready <= 1'b0;
        end else if (ready_gap > 0) begin
            i_ready   <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if ($urandom_range(0, 99) < 30) begin
            i_ready   <= 1'b0;
            ready_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(4, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Covers the field extremes and each named special case.
    task automatic test_directed();
        t_in cases[$];
        cases.push_back(make_vector(0, 0, 0, 32'h0001_0000));
        cases.push_back(make_vector(0, 0, 0, 0));
        cases.push_back(make_vector(0, 0, 0, 32'h8000_0000));
        cases.push_back(make_vector(32'h0003_0000, 32'h0004_0000, 0, 0));
        cases.push_back(make_vector(32'h0003_0000, 32'h0004_0000, 0, 32'h000A_0000));
        cases.push_back(make_vector(32'h0003_0000, 32'h0004_0000, 0, 32'hFFFF_0000));
        cases.push_back(make_vector(32'h8000_0000, 0, 0, 32'h8000_0000));
        cases.push_back(make_vector(0, 32'h8000_0000, 0, 32'h8000_0000));
        cases.push_back(make_vector(0, 0, 32'hFFFF_FFFF, 32'h8000_0000));
        cases.push_back(make_vector(32'h8000_0000, 0, 0, 32'h7FFF_FFFF));
        cases.push_back(make_vector(32'h7FFF_FFFF, 0, 0, 32'h8000_0000));
        cases.push_back(make_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
        cases.push_back(make_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h7FFF_FFFF));
        cases.push_back(make_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h8000_0000));
        cases.push_back(make_vector(1, 0, 0, 32'h7FFF_FFFF));
        cases.push_back(make_vector(0, 1, 1, 32'h8000_0000));
        cases.push_back(make_vector(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 5));
        cases.push_back(make_vector(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 1));
        foreach (cases[i]) send_vector(cases[i], random_gap());
        stop_input();
    endtask

    // Random vectors with back-to-back bursts and occasional long gaps.
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_vector(make_vector(random_field(), random_field(), random_field(),
                                    random_field()),
                        (i % 200 < 40) ? 0 : random_gap());
        end
        stop_input();
    endtask

    // Output held off so the pipeline fills, then the sender waits for a drain.
    task automatic test_stall_and_drain();
        sink_hold = 1'b1;
        fork
            begin
                repeat (3 * PIPE_LATENCY) @(posedge i_clk);
                sink_hold = 1'b0;
            end
        join_none
        for (int i = 0; i < 100; i++) begin
            send_vector(make_vector($urandom, $urandom, $urandom, $urandom), 0);
        end
        stop_input();
        sink_hold = 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        i_ready = 1'b0;
        sink_hold = 1'b0;
        mismatch_count = 0;
        checked_count = 0;
        sat_seen = 0;
        zero_seen = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(700);
        test_stall_and_drain();
        test_random(800);

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("Checked %0d rescaled vectors: %0d zero-length, %0d saturated.",
                 checked_count, zero_seen, sat_seen);
        $display("Directed extremes, random fields and a full-pipeline stall were run.");
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- vector3_normalize_to_magnitude.f -----
rtl/vnm_pkg.sv
rtl/vnm_sqrt.sv
rtl/vnm_div.sv
rtl/vector3_normalize_to_magnitude.sv
test/tb.sv
